[rtl/core/hbs_pkg.sv]
// shared types and constants for the height grid box smoother
// no dependencies; used by hbs_div and heightmap_box_smoothing
package hbs_pkg;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_RUN    = 2'd1,
        OP_READ   = 2'd2,
        OP_UNUSED = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_GRID_ROWS     = 2'd0,
        CFG_GRID_COLS     = 2'd1,
        CFG_PASS_COUNT    = 2'd2,
        CFG_WINDOW_RADIUS = 2'd3
    } cfg_index_t;

    // window is at most 31 x 31 cells, so the cell count fits in 10 bits
    localparam int CNT_W = 10;
    // signed width for row and column arithmetic, enough for 4096 plus sign
    localparam int IDX_W = 14;

endpackage

[rtl/core/hbs_div.sv]
// serial restoring divider: signed window sum by unsigned cell count,
// quotient truncated toward zero; uses hbs_pkg
module hbs_div #(
    parameter int SUM_W = 27,
    parameter int Q_W   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [SUM_W-1:0]      dividend,
    input  logic [hbs_pkg::CNT_W-1:0]    divisor,
    output logic                         done,
    output logic signed [Q_W-1:0]        quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic                        neg_reg;
    logic [STEP_W-1:0]           step_reg;
    logic [SUM_W-1:0]            work_reg;
    logic [hbs_pkg::CNT_W:0]     rem_reg;
    logic [hbs_pkg::CNT_W-1:0]   div_reg;

    logic [hbs_pkg::CNT_W:0]     shifted;
    logic                        ge;
    logic [SUM_W-1:0]            mag;
    logic [SUM_W-1:0]            q_signed;

    assign shifted  = {rem_reg[hbs_pkg::CNT_W-1:0], work_reg[SUM_W-1]};
    assign ge       = shifted >= {1'b0, div_reg};
    assign mag      = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
    assign q_signed = neg_reg ? (~work_reg + SUM_W'(1)) : work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W);
                work_reg <= mag;
                rem_reg  <= '0;
                div_reg  <= divisor;
                neg_reg  <= dividend[SUM_W-1];
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? (shifted - {1'b0, div_reg}) : shifted;
                work_reg <= {work_reg[SUM_W-2:0], ge};
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_signed[Q_W-1:0];

endmodule

[rtl/core/heightmap_box_smoothing.sv]
// Height grid box smoother: a single-port grid memory with write, clamped
// read and in-place box smoothing. A write (or unused opcode) answers from
// the idle state and a read via the read state, gated by the one output
// register. A run with nonzero pass count and radius visits every cell in
// raster order on each pass: it sets up the clipped window, reads it (one
// memory read per cycle on the single port), then runs the bit-serial
// divider and the write back. The store is not cleared after reset.
module heightmap_box_smoothing #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLS    = 256,
    parameter int HEIGHT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [8:0]                    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic signed [9:0]             row_index,
    input  logic signed [9:0]             col_index,
    input  logic signed [HEIGHT_BITS-1:0] height_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [HEIGHT_BITS-1:0] height_out,
    output logic                          status
);

    localparam int IW    = hbs_pkg::IDX_W;
    localparam int CW    = hbs_pkg::CNT_W;
    localparam int AW    = $clog2(MAX_ROWS * MAX_COLS);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int SUM_W = HEIGHT_BITS + CW + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CELL, S_ACC, S_TAIL, S_DSTART, S_DWAIT, S_WB
    } state_t;

    state_t                   state_reg;
    logic [8:0]               grid_rows_reg;
    logic [8:0]               grid_cols_reg;
    logic [3:0]               pass_count_reg;
    logic [3:0]               window_radius_reg;

    logic                     out_valid_reg;
    logic signed [HEIGHT_BITS-1:0] height_out_reg;
    logic                     status_reg;

    logic signed [IW-1:0]     r_reg, c_reg, i_reg, j_reg;
    logic signed [IW-1:0]     r0_reg, r1_reg, c0_reg, c1_reg;
    logic [3:0]               p_reg;
    logic                     rd_v_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [CW-1:0]            cnt_reg;

    logic signed [HEIGHT_BITS-1:0] height_store_mem [DEPTH];
    logic signed [HEIGHT_BITS-1:0] mem_q_reg;
    logic                     mem_we;
    logic [AW-1:0]            mem_addr;
    logic signed [HEIGHT_BITS-1:0] mem_wd;

    logic signed [IW-1:0]     rows, cols, gr, gc, rad, row_s, col_s, rr, cc;
    logic signed [IW-1:0]     mul_row, mul_col;
    logic [2*IW-1:0]          lin;
    logic                     in_fire, wr_ok, run_trivial;
    logic                     div_start, div_done;
    logic signed [HEIGHT_BITS-1:0] div_q;
    hbs_pkg::opcode_t         op;

    assign op  = hbs_pkg::opcode_t'(opcode);
    assign gr  = signed'({{(IW-9){1'b0}}, grid_rows_reg});
    assign gc  = signed'({{(IW-9){1'b0}}, grid_cols_reg});
    assign rad = signed'({{(IW-4){1'b0}}, window_radius_reg});

    // effective grid size clamped into [2, MAX]
    assign rows = (gr < IW'(2)) ? IW'(2) : ((gr > IW'(MAX_ROWS)) ? IW'(MAX_ROWS) : gr);
    assign cols = (gc < IW'(2)) ? IW'(2) : ((gc > IW'(MAX_COLS)) ? IW'(MAX_COLS) : gc);

    assign row_s = IW'(row_index);
    assign col_s = IW'(col_index);
    assign rr = (row_s < 0) ? '0 : ((row_s >= rows) ? rows - IW'(1) : row_s);
    assign cc = (col_s < 0) ? '0 : ((col_s >= cols) ? cols - IW'(1) : col_s);
    assign wr_ok = (row_s >= 0) && (row_s < rows) && (col_s >= 0) && (col_s < cols);
    assign run_trivial = (pass_count_reg == 4'd0) || (window_radius_reg == 4'd0);

    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        case (state_reg)
            S_ACC:
            begin
                mul_row = i_reg;
                mul_col = j_reg;
            end
            S_WB:
            begin
                mul_row = r_reg;
                mul_col = c_reg;
            end
            default:
            begin
                mul_row = rr;
                mul_col = cc;
            end
        endcase
    end

    assign lin      = (2*IW)'(mul_row) * (2*IW)'(cols) + (2*IW)'(mul_col);
    assign mem_addr = lin[AW-1:0];
    assign mem_we   = (state_reg == S_WB) || (in_fire && op == hbs_pkg::OP_WRITE && wr_ok);
    assign mem_wd   = (state_reg == S_WB) ? div_q : height_in;
    assign div_start = (state_reg == S_DSTART);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            height_store_mem[mem_addr] <= mem_wd;
        end
        mem_q_reg <= height_store_mem[mem_addr];
    end

    hbs_div #(
        .SUM_W (SUM_W),
        .Q_W   (HEIGHT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            grid_rows_reg     <= 9'd2;
            grid_cols_reg     <= 9'd2;
            pass_count_reg    <= 4'd0;
            window_radius_reg <= 4'd0;
            out_valid_reg     <= 1'b0;
            rd_v_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (hbs_pkg::cfg_index_t'(cfg_index))
                    hbs_pkg::CFG_GRID_ROWS:     grid_rows_reg     <= cfg_data;
                    hbs_pkg::CFG_GRID_COLS:     grid_cols_reg     <= cfg_data;
                    hbs_pkg::CFG_PASS_COUNT:    pass_count_reg    <= cfg_data[3:0];
                    hbs_pkg::CFG_WINDOW_RADIUS: window_radius_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            rd_v_reg <= (state_reg == S_ACC);
            if (rd_v_reg)
            begin
                sum_reg <= sum_reg + SUM_W'(mem_q_reg);
                cnt_reg <= cnt_reg + CW'(1);
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        case (op)
                            hbs_pkg::OP_READ:
                            begin
                                state_reg <= S_RD;
                            end
                            hbs_pkg::OP_RUN:
                            begin
                                if (run_trivial)
                                begin
                                    out_valid_reg  <= 1'b1;
                                    height_out_reg <= '0;
                                    status_reg     <= 1'b0;
                                end
                                else
                                begin
                                    r_reg     <= '0;
                                    c_reg     <= '0;
                                    p_reg     <= 4'd0;
                                    state_reg <= S_CELL;
                                end
                            end
                            hbs_pkg::OP_WRITE:
                            begin
                                out_valid_reg  <= 1'b1;
                                height_out_reg <= '0;
                                status_reg     <= !wr_ok;
                            end
                            default:
                            begin
                                out_valid_reg  <= 1'b1;
                                height_out_reg <= '0;
                                status_reg     <= 1'b0;
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    out_valid_reg  <= 1'b1;
                    height_out_reg <= mem_q_reg;
                    status_reg     <= 1'b0;
                    state_reg      <= S_IDLE;
                end
                S_CELL:
                begin
                    // clip the window at the grid edges
                    r0_reg    <= (r_reg - rad < 0) ? '0 : r_reg - rad;
                    r1_reg    <= (r_reg + rad > rows - IW'(1)) ? rows - IW'(1) : r_reg + rad;
                    c0_reg    <= (c_reg - rad < 0) ? '0 : c_reg - rad;
                    c1_reg    <= (c_reg + rad > cols - IW'(1)) ? cols - IW'(1) : c_reg + rad;
                    i_reg     <= (r_reg - rad < 0) ? '0 : r_reg - rad;
                    j_reg     <= (c_reg - rad < 0) ? '0 : c_reg - rad;
                    sum_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (j_reg == c1_reg)
                    begin
                        j_reg <= c0_reg;
                        if (i_reg == r1_reg)
                        begin
                            state_reg <= S_TAIL;
                        end
                        else
                        begin
                            i_reg <= i_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + IW'(1);
                    end
                end
                S_TAIL:
                begin
                    // last read beat lands in the sum this cycle
                    state_reg <= S_DSTART;
                end
                S_DSTART:
                begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    state_reg <= S_CELL;
                    if (c_reg == cols - IW'(1))
                    begin
                        c_reg <= '0;
                        if (r_reg == rows - IW'(1))
                        begin
                            r_reg <= '0;
                            if (p_reg == pass_count_reg - 4'd1)
                            begin
                                out_valid_reg  <= 1'b1;
                                height_out_reg <= '0;
                                status_reg     <= 1'b0;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                p_reg <= p_reg + 4'd1;
                            end
                        end
                        else
                        begin
                            r_reg <= r_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        c_reg <= c_reg + IW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign height_out = height_out_reg;
    assign status     = status_reg;

    a_mem_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_WB) || (in_fire && op == hbs_pkg::OP_WRITE))
        else $error("grid written outside a write beat or write back");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DWAIT)
        else $error("divider finished outside its wait state");

    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && op == hbs_pkg::OP_RUN && !run_trivial) |=> state_reg == S_CELL)
        else $error("run beat did not start the cell sweep");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> !out_valid_reg)
        else $error("read result would overwrite a pending beat");

endmodule
